// File: hw/rtl/nnr_pkg.sv
package nnr_pkg;

  localparam int MAX_ROWS_DEF  = 512;
  localparam int MAX_COLS_DEF  = 512;
  localparam int FRAC_BITS_DEF = 4;

  localparam int PIX_W   = 24;
  localparam int COORD_W = 16;
  localparam int LOAD_W  = 9;
  localparam int SIZE_W  = 10;
  localparam int CMP_W   = 18;
  localparam int PADDR_W = 4;

  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_MODE  = 2'd2;
  localparam logic [1:0] REG_EDGE  = 2'd3;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic MODE_REPLICATE = 1'b0;
  localparam logic MODE_CONSTANT  = 1'b1;

  typedef struct packed {
    logic [SIZE_W-1:0] image_rows;
    logic [SIZE_W-1:0] image_cols;
    logic              edge_mode;
    logic [7:0]        edge_value;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic lookup;
    logic we;
    logic outside;
    logic use_edge;
  } pipe_ctl_t;

endpackage

// File: hw/rtl/nnr_cfg.sv
module nnr_cfg
  import nnr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_rows <= SIZE_W'(512);
      cfg.image_cols <= SIZE_W'(512);
      cfg.edge_mode  <= MODE_REPLICATE;
      cfg.edge_value <= 8'd0;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_ROWS: cfg.image_rows <= pwdata[SIZE_W-1:0];
        REG_COLS: cfg.image_cols <= pwdata[SIZE_W-1:0];
        REG_MODE: cfg.edge_mode  <= pwdata[0];
        REG_EDGE: cfg.edge_value <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROWS: prdata = 32'(cfg.image_rows);
      REG_COLS: prdata = 32'(cfg.image_cols);
      REG_MODE: prdata = 32'(cfg.edge_mode);
      REG_EDGE: prdata = 32'(cfg.edge_value);
      default:  prdata = 32'd0;
    endcase
  end

endmodule

// File: hw/rtl/nnr_addr_pipe.sv
module nnr_addr_pipe
  import nnr_pkg::*;
#(
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int MAX_COLS  = MAX_COLS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  cfg_t                                     cfg,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     func,
  input  logic [LOAD_W-1:0]                        load_row,
  input  logic [LOAD_W-1:0]                        load_col,
  input  logic [PIX_W-1:0]                         load_pixel,
  input  logic signed [COORD_W-1:0]                map_row_fix,
  input  logic signed [COORD_W-1:0]                map_col_fix,
  input  logic                                     en_down,
  output pipe_ctl_t                                ctl3,
  output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]     addr3,
  output logic [PIX_W-1:0]                         wdata3
);

  localparam int AW    = $clog2(MAX_ROWS * MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RND_W = COORD_W + 1 - FRAC_BITS;
  localparam int SZR_W = $clog2(MAX_ROWS + 1);
  localparam int SZC_W = $clog2(MAX_COLS + 1);
  localparam logic signed [COORD_W:0] HALF =
    (FRAC_BITS > 0) ? (COORD_W+1)'(1 << (FRAC_BITS - 1)) : '0;

  logic en1, en2, en3;

  logic                    v1, func1, ok1;
  logic [LOAD_W-1:0]       lrow1, lcol1;
  logic [PIX_W-1:0]        pix1;
  logic signed [RND_W-1:0] r1, c1;

  logic              v2, lookup2, we2, outside2, use_edge2;
  logic [RW-1:0]     row2;
  logic [CW-1:0]     col2;
  logic [PIX_W-1:0]  pix2;

  logic signed [COORD_W:0] t_row, t_col;
  logic                    load_ok;

  logic [SZR_W-1:0]        rows_eff;
  logic [SZC_W-1:0]        cols_eff;
  logic signed [CMP_W-1:0] rows_s, cols_s, r_s, c_s;
  logic                    outside;
  logic [RW-1:0]           rr;
  logic [CW-1:0]           cc;

  assign en3      = !ctl3.valid || en_down;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  assign t_row   = (COORD_W+1)'(map_row_fix) + HALF;
  assign t_col   = (COORD_W+1)'(map_col_fix) + HALF;
  assign load_ok = (32'(load_row) < MAX_ROWS) && (32'(load_col) < MAX_COLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      func1 <= func;
      ok1   <= load_ok;
      lrow1 <= load_row;
      lcol1 <= load_col;
      pix1  <= load_pixel;
      r1    <= RND_W'(t_row >>> FRAC_BITS);
      c1    <= RND_W'(t_col >>> FRAC_BITS);
    end
  end

  always_comb begin
    if (cfg.image_rows == '0) begin
      rows_eff = SZR_W'(1);
    end else if (32'(cfg.image_rows) > MAX_ROWS) begin
      rows_eff = SZR_W'(MAX_ROWS);
    end else begin
      rows_eff = SZR_W'(cfg.image_rows);
    end
    if (cfg.image_cols == '0) begin
      cols_eff = SZC_W'(1);
    end else if (32'(cfg.image_cols) > MAX_COLS) begin
      cols_eff = SZC_W'(MAX_COLS);
    end else begin
      cols_eff = SZC_W'(cfg.image_cols);
    end
    rows_s  = CMP_W'(rows_eff);
    cols_s  = CMP_W'(cols_eff);
    r_s     = CMP_W'(r1);
    c_s     = CMP_W'(c1);
    outside = (r_s < 0) || (r_s >= rows_s) || (c_s < 0) || (c_s >= cols_s);
    if (r_s < 0) begin
      rr = '0;
    end else if (r_s >= rows_s) begin
      rr = RW'(rows_s - CMP_W'(1));
    end else begin
      rr = RW'(r_s);
    end
    if (c_s < 0) begin
      cc = '0;
    end else if (c_s >= cols_s) begin
      cc = CW'(cols_s - CMP_W'(1));
    end else begin
      cc = CW'(c_s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      lookup2   <= (func1 == FUNC_LOOKUP);
      we2       <= (func1 == FUNC_LOAD) && ok1;
      outside2  <= outside;
      use_edge2 <= outside && (cfg.edge_mode == MODE_CONSTANT);
      row2      <= (func1 == FUNC_LOOKUP) ? rr : RW'(lrow1);
      col2      <= (func1 == FUNC_LOOKUP) ? cc : CW'(lcol1);
      pix2      <= pix1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3.valid <= 1'b0;
    end else if (en3) begin
      ctl3.valid <= v2;
    end
    if (en3) begin
      ctl3.lookup   <= lookup2;
      ctl3.we       <= we2;
      ctl3.outside  <= outside2;
      ctl3.use_edge <= use_edge2;
      addr3         <= AW'(row2) * AW'(MAX_COLS) + AW'(col2);
      wdata3        <= pix2;
    end
  end

endmodule

// File: hw/rtl/nnr_store.sv
module nnr_store
  import nnr_pkg::*;
#(
  parameter int DEPTH = MAX_ROWS_DEF * MAX_COLS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [PIX_W-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [PIX_W-1:0]         rdata
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/nearest_neighbor_remap.sv
// Channel   Handshake            Payload
// req       req_valid/req_stall  func, load_row, load_col, load_pixel, map_row_fix, map_col_fix
// rsp       rsp_valid/rsp_stall  pixel_out, was_outside
// apb       psel/penable/pready  pwrite, paddr, pwdata, prdata
//
// One transfer is taken in every cycle while req_stall is low; a lookup's result is offered from the output register.
// The five register stages are rounding, range check and clamp, address multiply,
// the registered read of the image memory, and the output register.
// Reset clears the valid bits and the configuration registers only; the image memory is not cleared.
// A stall holds each stage that is full and lets earlier stages close up their bubbles.
module nearest_neighbor_remap
  import nnr_pkg::*;
#(
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int MAX_COLS  = MAX_COLS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic                      func,
  input  logic [LOAD_W-1:0]         load_row,
  input  logic [LOAD_W-1:0]         load_col,
  input  logic [PIX_W-1:0]          load_pixel,
  input  logic signed [COORD_W-1:0] map_row_fix,
  input  logic signed [COORD_W-1:0] map_col_fix,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic [PIX_W-1:0]          pixel_out,
  output logic                      was_outside,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  cfg_t             cfg;
  pipe_ctl_t        ctl3;
  logic [AW-1:0]    addr3;
  logic [PIX_W-1:0] wdata3;
  logic [PIX_W-1:0] rdata;
  logic             en4, en5;
  logic             v4, outside4, use_edge4;

  assign en5 = !rsp_valid || !rsp_stall;
  assign en4 = !v4 || en5;

  nnr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nnr_addr_pipe #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .FRAC_BITS (FRAC_BITS)
  ) u_addr_pipe (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (req_valid),
    .in_stall    (req_stall),
    .func        (func),
    .load_row    (load_row),
    .load_col    (load_col),
    .load_pixel  (load_pixel),
    .map_row_fix (map_row_fix),
    .map_col_fix (map_col_fix),
    .en_down     (en4),
    .ctl3        (ctl3),
    .addr3       (addr3),
    .wdata3      (wdata3)
  );

  nnr_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (en4 && ctl3.valid && ctl3.we),
    .waddr (addr3),
    .wdata (wdata3),
    .re    (en4),
    .raddr (addr3),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= ctl3.valid && ctl3.lookup;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      outside4  <= ctl3.outside;
      use_edge4 <= ctl3.use_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en5) begin
      rsp_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      pixel_out   <= use_edge4 ? {3{cfg.edge_value}} : rdata;
      was_outside <= outside4;
    end
  end

`ifndef SYNTHESIS
  a_edge_only_outside: assert property (@(posedge clk) disable iff (rst)
    v4 && use_edge4 |-> outside4)
    else $error("border value chosen for an inside pixel");

  a_no_write_on_lookup: assert property (@(posedge clk) disable iff (rst)
    ctl3.valid && ctl3.we |-> !ctl3.lookup)
    else $error("memory write issued for a lookup");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall && v4 && ctl3.valid)
    else $error("input stalled while the pipeline has a bubble");

  a_rsp_from_stage4: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !$past(rsp_valid) |-> $past(v4))
    else $error("result appeared without a lookup in the read stage");
`endif

endmodule

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nnr_pkg::*;

  localparam int MAXR = MAX_ROWS_DEF;
  localparam int MAXC = MAX_COLS_DEF;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam int ONE = 1 << FRAC;
  localparam int HALF = (FRAC > 0) ? (ONE >> 1) : 0;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             outside;
  } remap_result_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      req_valid;
  logic                      req_stall;
  logic                      func;
  logic [LOAD_W-1:0]         load_row;
  logic [LOAD_W-1:0]         load_col;
  logic [PIX_W-1:0]          load_pixel;
  logic signed [COORD_W-1:0] map_row_fix;
  logic signed [COORD_W-1:0] map_col_fix;
  logic                      rsp_valid;
  logic                      rsp_stall = 1'b0;
  logic [PIX_W-1:0]          pixel_out;
  logic                      was_outside;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;

  nearest_neighbor_remap dut (.*);

  always #2 clk = ~clk;

  logic [PIX_W-1:0]  image_copy [int];
  int                loaded_addr_q [$];
  remap_result_t     expected_px_q [$];
  logic [SIZE_W-1:0] cfg_rows = SIZE_W'(512);
  logic [SIZE_W-1:0] cfg_cols = SIZE_W'(512);
  logic              cfg_mode = MODE_REPLICATE;
  logic [7:0]        cfg_edge = 8'd0;

  int error_count = 0;
  int n_loads = 0;
  int n_lookups = 0;
  int n_checked = 0;
  int n_outside = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;
  bit sender_steady = 1'b0;
  bit rsp_steady = 1'b0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  function automatic void flag_error(string what);
    error_count++;
    if (error_count <= REPORT_MAX) $display("ERROR: %s", what);
  endfunction

  function automatic int eff_size(logic [SIZE_W-1:0] v, int lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic int clamp(int v, int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  // Returns the store address that a lookup reads, or -1 when the border level is used.
  function automatic int source_addr(logic signed [COORD_W-1:0] mr,
                                     logic signed [COORD_W-1:0] mc, output logic outside);
    int rows, cols, r, c;
    rows = eff_size(cfg_rows, MAXR);
    cols = eff_size(cfg_cols, MAXC);
    r = (int'(mr) + HALF) >>> FRAC;
    c = (int'(mc) + HALF) >>> FRAC;
    outside = (r < 0) || (r >= rows) || (c < 0) || (c >= cols);
    if (cfg_mode == MODE_CONSTANT && outside) return -1;
    return clamp(r, rows - 1) * MAXC + clamp(c, cols - 1);
  endfunction

  function automatic remap_result_t predict_remap(logic signed [COORD_W-1:0] mr,
                                                  logic signed [COORD_W-1:0] mc);
    remap_result_t res;
    int addr;
    logic outside;
    addr = source_addr(mr, mc, outside);
    res.outside = outside;
    if (addr < 0) res.pixel = {3{cfg_edge}};
    else res.pixel = image_copy.exists(addr) ? image_copy[addr] : '0;
    return res;
  endfunction

  function automatic bit reads_written(logic signed [COORD_W-1:0] mr,
                                       logic signed [COORD_W-1:0] mc);
    int addr;
    logic outside;
    addr = source_addr(mr, mc, outside);
    return (addr < 0) || image_copy.exists(addr);
  endfunction

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (expected_px_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ROWS: cfg_rows = value[SIZE_W-1:0];
      REG_COLS: cfg_cols = value[SIZE_W-1:0];
      REG_MODE: cfg_mode = value[0];
      REG_EDGE: cfg_edge = value[7:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic send_item(logic f, logic [LOAD_W-1:0] lr, logic [LOAD_W-1:0] lc,
                           logic [PIX_W-1:0] lp, logic signed [COORD_W-1:0] mr,
                           logic signed [COORD_W-1:0] mc);
    int addr;
    while (!sender_steady && $urandom_range(99) < 8) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    func <= f;
    load_row <= lr;
    load_col <= lc;
    load_pixel <= lp;
    map_row_fix <= mr;
    map_col_fix <= mc;
    do @(posedge clk); while (req_stall);
    if (f == FUNC_LOAD) begin
      addr = int'(lr) * MAXC + int'(lc);
      if (int'(lr) < MAXR && int'(lc) < MAXC) begin
        if (!image_copy.exists(addr)) loaded_addr_q.push_back(addr);
        image_copy[addr] = lp;
      end
      n_loads++;
    end else begin
      expected_px_q.push_back(predict_remap(mr, mc));
      n_lookups++;
    end
    @(negedge clk);
  endtask

  task automatic send_load(int r, int c, logic [PIX_W-1:0] pix);
    send_item(FUNC_LOAD, LOAD_W'(r), LOAD_W'(c), pix, COORD_W'($urandom()),
              COORD_W'($urandom()));
  endtask

  task automatic send_lookup(logic signed [COORD_W-1:0] mr, logic signed [COORD_W-1:0] mc);
    send_item(FUNC_LOOKUP, LOAD_W'($urandom()), LOAD_W'($urandom()), PIX_W'($urandom()),
              mr, mc);
  endtask

  task automatic send_lookup_random();
    logic signed [COORD_W-1:0] mr, mc;
    int kind, tries, pick, rows, cols;
    rows = eff_size(cfg_rows, MAXR);
    cols = eff_size(cfg_cols, MAXC);
    tries = 0;
    do begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        mr = COORD_W'($urandom());
        mc = COORD_W'($urandom());
      end else if (kind < 65) begin
        pick = loaded_addr_q[$urandom_range(loaded_addr_q.size() - 1)];
        mr = COORD_W'((pick / MAXC) * ONE + int'($urandom_range(ONE - 1)) - HALF);
        mc = COORD_W'((pick % MAXC) * ONE + int'($urandom_range(ONE - 1)) - HALF);
      end else begin
        mr = COORD_W'((int'($urandom_range(rows + 3)) - 2) * ONE
                      + int'($urandom_range(ONE - 1)) - HALF);
        mc = COORD_W'((int'($urandom_range(cols + 3)) - 2) * ONE
                      + int'($urandom_range(ONE - 1)) - HALF);
      end
      tries++;
    end while (!reads_written(mr, mc) && tries < 40);
    if (!reads_written(mr, mc)) begin
      mr = COORD_W'(int'($urandom_range(ONE - 1)) - HALF);
      mc = COORD_W'(int'($urandom_range(ONE - 1)) - HALF);
    end
    send_lookup(mr, mc);
  endtask

  task automatic send_mixed(int count);
    int rows, cols;
    rows = eff_size(cfg_rows, MAXR);
    cols = eff_size(cfg_cols, MAXC);
    repeat (count) begin
      if ($urandom_range(99) < 20)
        send_load($urandom_range(rows - 1), $urandom_range(cols - 1), PIX_W'($urandom()));
      else
        send_lookup_random();
    end
  endtask

  task automatic test_directed();
    send_load(0, 0, 24'h000000);
    send_load(0, 511, 24'hFFFFFF);
    send_load(511, 0, 24'h123456);
    send_load(511, 511, 24'hABCDEF);
    send_load(0, 1, 24'h010203);
    send_load(1, 0, 24'h0A0B0C);
    send_load(1, 1, 24'h800080);
    send_lookup(16'sh7FFF, 16'sh7FFF);
    send_lookup(-16'sh8000, -16'sh8000);
    send_lookup(-16'sh8000, 16'sh7FFF);
    send_lookup(16'sh7FFF, -16'sh8000);
    send_lookup(16'sd7, 16'sd7);
    send_lookup(16'sd8, 16'sd8);
    send_lookup(-16'sd8, 16'sd8);
    send_lookup(-16'sd9, -16'sd9);
    send_load(2, 2, 24'h5A5A5A);
    send_lookup(16'sd32, 16'sd32);
    write_reg(REG_MODE, 32'(MODE_CONSTANT));
    write_reg(REG_EDGE, 32'hA5);
    send_lookup(-16'sd9, 16'sd0);
    send_lookup(16'sd0, 16'sd0);
    send_lookup(16'sh7FFF, 16'sh7FFF);
    write_reg(REG_ROWS, 32'd0);
    write_reg(REG_COLS, 32'd1023);
    send_lookup(16'sd16, 16'sd0);
    send_lookup(16'sd0, COORD_W'(511 * ONE));
    write_reg(REG_MODE, 32'(MODE_REPLICATE));
    send_lookup(16'sd16, 16'sd0);
  endtask

  task automatic test_small_images();
    int rows_reg, cols_reg, rows, cols;
    for (int k = 0; k < 10; k++) begin
      case (k)
        0: begin rows_reg = 1; cols_reg = 1; end
        1: begin rows_reg = 1; cols_reg = 8; end
        2: begin rows_reg = 0; cols_reg = 5; end
        3: begin rows_reg = 8; cols_reg = 1; end
        default: begin
          rows_reg = $urandom_range(8, 1);
          cols_reg = $urandom_range(8, 1);
        end
      endcase
      write_reg(REG_ROWS, 32'(rows_reg));
      write_reg(REG_COLS, 32'(cols_reg));
      write_reg(REG_MODE, (k % 2 == 0) ? 32'(MODE_REPLICATE) : 32'(MODE_CONSTANT));
      write_reg(REG_EDGE, (k == 1) ? 32'd255 : (k == 3) ? 32'd0 : 32'($urandom_range(255)));
      rows = eff_size(cfg_rows, MAXR);
      cols = eff_size(cfg_cols, MAXC);
      for (int r = 0; r < rows; r++)
        for (int c = 0; c < cols; c++) send_load(r, c, PIX_W'($urandom()));
      repeat (4) send_load($urandom_range(MAXR - 1), $urandom_range(MAXC - 1),
                           PIX_W'($urandom()));
      send_mixed(50);
    end
  endtask

  task automatic test_backpressure();
    sender_steady = 1'b1;
    hold_token++;
    repeat (60) send_lookup_random();
    sender_steady = 1'b0;
  endtask

  task automatic test_large_image();
    write_reg(REG_ROWS, 32'd512);
    write_reg(REG_COLS, 32'd512);
    write_reg(REG_MODE, 32'(MODE_REPLICATE));
    send_load(0, 0, PIX_W'($urandom()));
    send_load(0, 511, PIX_W'($urandom()));
    send_load(511, 0, PIX_W'($urandom()));
    send_load(511, 511, PIX_W'($urandom()));
    repeat (40) send_load($urandom_range(MAXR - 1), $urandom_range(MAXC - 1),
                          PIX_W'($urandom()));
    repeat (50) send_lookup_random();
    write_reg(REG_MODE, 32'(MODE_CONSTANT));
    write_reg(REG_EDGE, 32'd255);
    repeat (30) send_lookup_random();
    write_reg(REG_ROWS, 32'd1023);
    write_reg(REG_COLS, 32'd300);
    write_reg(REG_MODE, 32'(MODE_REPLICATE));
    repeat (30) send_lookup_random();
  endtask

  task automatic test_steady_stream();
    write_reg(REG_ROWS, 32'd8);
    write_reg(REG_COLS, 32'd8);
    write_reg(REG_MODE, 32'(MODE_CONSTANT));
    write_reg(REG_EDGE, 32'($urandom_range(255)));
    sender_steady = 1'b1;
    rsp_steady = 1'b1;
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++) send_load(r, c, PIX_W'($urandom()));
    send_mixed(80);
    wait_idle();
    sender_steady = 1'b0;
    rsp_steady = 1'b0;
  endtask

  always @(negedge clk) begin : drive_rsp_stall
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES - 1;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= !rsp_steady && ($urandom_range(99) < 8);
    end
  end

  always @(posedge clk) begin : check_results
    remap_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_px_q.size() == 0) begin
        flag_error($sformatf("result with nothing expected: pixel %06h outside %0b",
                             pixel_out, was_outside));
      end else begin
        want = expected_px_q.pop_front();
        if (want.pixel !== pixel_out || want.outside !== was_outside)
          flag_error($sformatf("pixel expected %06h got %06h, outside expected %0b got %0b",
                               want.pixel, pixel_out, want.outside, was_outside));
        n_checked++;
        if (was_outside === 1'b1) n_outside++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_px_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : run
    rst = 1'b1;
    req_valid = 1'b0;
    func = FUNC_LOAD;
    load_row = '0;
    load_col = '0;
    load_pixel = '0;
    map_row_fix = '0;
    map_col_fix = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_small_images();
    test_backpressure();
    test_large_image();
    test_steady_stream();
    wait_idle();
    $display("Sent %0d pixel loads and %0d remap lookups across %0d register writes.",
             n_loads, n_lookups, cfg_writes);
    $display("Checked %0d results, %0d outside the image; %0d errors.",
             n_checked, n_outside, error_count);
    if (error_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/nnr_pkg.sv
hw/rtl/nnr_cfg.sv
hw/rtl/nnr_addr_pipe.sv
hw/rtl/nnr_store.sv
hw/rtl/nearest_neighbor_remap.sv
dv/tb.sv
